/* src/security_association_table_top_assert.svh */
// Assertion macros for the security association table checker.
// Depends on i_clk and i_rst_n being visible where a macro is used.
`ifndef SECURITY_ASSOCIATION_TABLE_TOP_ASSERT_SVH
`define SECURITY_ASSOCIATION_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define SAT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SAT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sat_pkg.sv */
// Shared constants and types for the security association table.
// No dependencies.
package sat_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W   = 64;
    localparam int POL_W   = 8;
    localparam int DATA_W  = KEY_W + POL_W;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EXEC,
        S_OUT
    } t_state;

endpackage

/* src/sat_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/security_association_table_top.sv */
// Security association table: exact-match SPI store with scan controller.
// Depends on sat_pkg and sat_ram.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the operation
//   (lookup, insert, delete, clear), tdata the 64-bit SPI and the policy
//   id used by insert. One result per request leaves on m_axis: tdata
//   holds the policy id of the matching entry, tuser the found flag and
//   the status code.
//   Each request scans every slot of the key/policy RAM, one read per
//   cycle, and the block takes no new request until the result has been
//   loaded into the output register. The lowest free slot is found
//   during the same scan; insert writes the key and policy id to it
//   in the execute state.
//   Valid marks live in flip-flops and are cleared at reset and by the
//   clear operation; RAM contents need no clearing.
//   The result sits in an output register. A new request is taken while
//   it waits, but the next result is held back until the receiver has
//   taken the previous one.
module security_association_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] spi_key, [71:64] policy_id_in
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] policy_id_out
    output logic [2:0]  m_axis_tuser    // [0] found, [2:1] status
);

    sat_pkg::t_state r_state, n_state;

    logic [sat_pkg::ENTRIES-1:0] r_valid;
    logic [sat_pkg::OP_W-1:0]    r_op;
    logic [sat_pkg::KEY_W-1:0]   r_key;
    logic [sat_pkg::POL_W-1:0]   r_pol;
    logic [sat_pkg::IDX_W-1:0]   r_scan;
    logic [sat_pkg::IDX_W-1:0]   r_cmp_idx;
    logic                        r_cmp_vld;
    logic                        r_hit;
    logic [sat_pkg::IDX_W-1:0]   r_hit_idx;
    logic [sat_pkg::POL_W-1:0]   r_hit_pol;
    logic                        r_free;
    logic [sat_pkg::IDX_W-1:0]   r_free_idx;
    logic [sat_pkg::ST_W-1:0]    r_status;

    logic                        r_m_valid;
    logic [sat_pkg::POL_W-1:0]   r_m_pol;
    logic                        r_m_found;
    logic [sat_pkg::ST_W-1:0]    r_m_status;

    logic                        ram_we;
    logic                        ram_re;
    logic [sat_pkg::DATA_W-1:0]  ram_rdata;
    logic                        scan_last;
    logic                        cmp_match;
    logic                        cmp_free;
    logic                        out_load;
    logic                        in_acc;

    sat_ram #(
        .WIDTH (sat_pkg::DATA_W),
        .DEPTH (sat_pkg::ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata ({r_key, r_pol}),
        .i_re    (ram_re),
        .i_raddr (r_scan),
        .o_rdata (ram_rdata)
    );

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign scan_last = (r_scan == sat_pkg::IDX_W'(sat_pkg::ENTRIES - 1));
    assign cmp_match = r_cmp_vld && r_valid[r_cmp_idx]
                       && (ram_rdata[sat_pkg::DATA_W-1:sat_pkg::POL_W] == r_key);
    assign cmp_free  = r_cmp_vld && !r_valid[r_cmp_idx] && !r_free;
    assign out_load  = (r_state == sat_pkg::S_OUT) && (!r_m_valid || m_axis_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sat_pkg::S_IDLE: begin
                if (in_acc) n_state = sat_pkg::S_SCAN;
            end
            sat_pkg::S_SCAN: begin
                if (scan_last) n_state = sat_pkg::S_DRAIN;
            end
            sat_pkg::S_DRAIN: n_state = sat_pkg::S_EXEC;
            sat_pkg::S_EXEC:  n_state = sat_pkg::S_OUT;
            sat_pkg::S_OUT: begin
                if (out_load) n_state = sat_pkg::S_IDLE;
            end
            default: n_state = sat_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        case (r_state)
            sat_pkg::S_IDLE: s_axis_tready = 1'b1;
            sat_pkg::S_SCAN: ram_re = 1'b1;
            sat_pkg::S_EXEC: ram_we = (r_op == sat_pkg::OP_INSERT) && !r_hit && r_free;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sat_pkg::S_IDLE;
            r_valid   <= '0;
            r_cmp_vld <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == sat_pkg::S_SCAN);
            if (r_state == sat_pkg::S_EXEC) begin
                case (r_op)
                    sat_pkg::OP_INSERT: begin
                        if (!r_hit && r_free) r_valid[r_free_idx] <= 1'b1;
                    end
                    sat_pkg::OP_DELETE: begin
                        if (r_hit) r_valid[r_hit_idx] <= 1'b0;
                    end
                    sat_pkg::OP_CLEAR: r_valid <= '0;
                    default: r_valid <= r_valid;
                endcase
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // request capture, scan and result datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= s_axis_tuser;
            r_key  <= s_axis_tdata[sat_pkg::KEY_W-1:0];
            r_pol  <= s_axis_tdata[sat_pkg::DATA_W-1:sat_pkg::KEY_W];
            r_scan <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end
        if (r_state == sat_pkg::S_SCAN) begin
            r_cmp_idx <= r_scan;
            if (!scan_last) r_scan <= r_scan + 1'b1;
        end
        if (cmp_match) begin
            r_hit     <= 1'b1;
            r_hit_idx <= r_cmp_idx;
            r_hit_pol <= ram_rdata[sat_pkg::POL_W-1:0];
        end
        if (cmp_free) begin
            r_free     <= 1'b1;
            r_free_idx <= r_cmp_idx;
        end
        if (r_state == sat_pkg::S_EXEC) begin
            if (r_op != sat_pkg::OP_INSERT) r_status <= sat_pkg::ST_OK;
            else if (r_hit)                 r_status <= sat_pkg::ST_PRESENT;
            else if (!r_free)               r_status <= sat_pkg::ST_FULL;
            else                            r_status <= sat_pkg::ST_OK;
        end
        if (out_load) begin
            r_m_found  <= r_hit;
            r_m_pol    <= r_hit ? r_hit_pol : '0;
            r_m_status <= r_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_pol;
    assign m_axis_tuser  = {r_m_status, r_m_found};

endmodule

/* src/security_association_table_top_checker.sv */
// Port-level checker for the security association table, bound to the top.
// Depends on security_association_table_top_assert.svh and sat_pkg.
`include "security_association_table_top_assert.svh"

module security_association_table_top_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic        s_acc;
    logic        m_stall;
    logic [10:0] m_word;
    logic        m_found;
    logic [1:0]  m_status;
    logic        m_present;
    logic        m_full;
    logic        m_miss;

    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign m_stall   = m_axis_tvalid && !m_axis_tready;
    assign m_word    = {m_axis_tuser, m_axis_tdata};
    assign m_found   = m_axis_tuser[0];
    assign m_status  = m_axis_tuser[2:1];
    assign m_present = m_axis_tvalid && (m_status == sat_pkg::ST_PRESENT);
    assign m_full    = m_axis_tvalid && (m_status == sat_pkg::ST_FULL);
    assign m_miss    = m_axis_tvalid && !m_found;

    `SAT_ASSERT_NXT(a_hold, m_stall, m_axis_tvalid && $stable(m_word), "stalled result changed")
    `SAT_ASSERT_NXT(a_busy, s_acc, !s_axis_tready, "request taken while busy")
    `SAT_ASSERT_NOW(a_present_found, m_present, m_found, "present status without hit")
    `SAT_ASSERT_NOW(a_full_miss, m_full, !m_found, "full status with hit")
    `SAT_ASSERT_NOW(a_miss_zero, m_miss, m_axis_tdata == 8'd0, "policy on miss")

endmodule

bind security_association_table_top security_association_table_top_checker u_chk (.*);

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench for security_association_table_top: a shadow copy of the SA table predicts
// the result of each request, and a random stream of requests exercises the block.
// Depends on sat_pkg and the RTL of the table.

typedef struct packed {
    logic                        found;
    logic [sat_pkg::POL_W-1:0]   policy;
    logic [sat_pkg::ST_W-1:0]    status;
} t_sa_result;

class t_sa_shadow_table;
    bit                        slot_used   [sat_pkg::ENTRIES];
    logic [sat_pkg::KEY_W-1:0] slot_key    [sat_pkg::ENTRIES];
    logic [sat_pkg::POL_W-1:0] slot_policy [sat_pkg::ENTRIES];
    t_sa_result                pending_results [$];
    int                        errors;
    int                        n_results;

    function new();
        slot_used = '{default: 1'b0};
        errors    = 0;
        n_results = 0;
    endfunction

    task report(string what);
        $display("tb: result %0d: %s", n_results, what);
        errors++;
    endtask

    // accepted request: update the shadow table, queue the expected result
    function void predict_request(logic [sat_pkg::OP_W-1:0] op,
                                  logic [sat_pkg::KEY_W-1:0] key,
                                  logic [sat_pkg::POL_W-1:0] pol);
        int         hit;
        int         free_slot;
        t_sa_result res;
        hit       = -1;
        free_slot = -1;
        for (int i = 0; i < sat_pkg::ENTRIES; i++) begin
            if (slot_used[i] && slot_key[i] == key && hit < 0) hit = i;
            if (!slot_used[i] && free_slot < 0) free_slot = i;
        end
        res.found  = (hit >= 0);
        res.policy = (hit >= 0) ? slot_policy[hit] : '0;
        res.status = sat_pkg::ST_OK;
        case (op)
            sat_pkg::OP_INSERT: begin
                if (hit >= 0) begin
                    res.status = sat_pkg::ST_PRESENT;
                end else if (free_slot < 0) begin
                    res.status = sat_pkg::ST_FULL;
                end else begin
                    slot_used[free_slot]   = 1'b1;
                    slot_key[free_slot]    = key;
                    slot_policy[free_slot] = pol;
                end
            end
            sat_pkg::OP_DELETE: begin
                if (hit >= 0) slot_used[hit] = 1'b0;
            end
            sat_pkg::OP_CLEAR: begin
                slot_used = '{default: 1'b0};
            end
            default: ;
        endcase
        pending_results.push_back(res);
    endfunction

    // tuser: [0] found, [2:1] status
    task check_result(logic [7:0] pol, logic [2:0] user);
        t_sa_result want;
        if (pending_results.size() == 0) begin
            report($sformatf("no request pending, got policy %0h tuser %0h", pol, user));
        end else begin
            want = pending_results.pop_front();
            if (user[0] !== want.found)
                report($sformatf("found %0b, want %0b", user[0], want.found));
            if (pol !== want.policy)
                report($sformatf("policy %0h, want %0h", pol, want.policy));
            if (user[2:1] !== want.status)
                report($sformatf("status %0d, want %0d", user[2:1], want.status));
        end
        n_results++;
    endtask
endclass

module tb;
    import sat_pkg::*;

    localparam int N_RANDOM       = 1550;
    localparam int POOL_MAX       = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = ENTRIES + 8;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;    // [63:0] spi_key, [71:64] policy_id_in
    logic [1:0]  s_axis_tuser  = '0;    // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [7:0] policy_id_out
    logic [2:0]  m_axis_tuser;          // [0] found, [2:1] status

    t_sa_shadow_table    table_model = new();
    int                  burst_left  = 0;
    int                  idle_cycles = 0;
    int                  rx_mode     = 0;
    int                  rx_mode_left = 0;
    logic [KEY_W-1:0]    key_pool [POOL_MAX];

    security_association_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sender idles between bursts of random length
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [POL_W-1:0] pol);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pol, key};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        table_model.predict_request(op, key, pol);
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // receiver: ready pattern switches between modes at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            table_model.check_result(m_axis_tdata, m_axis_tuser);
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(10, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= $urandom_range(0, 1);
            2:       m_axis_tready <= ($urandom_range(0, 5) == 0);
            default: m_axis_tready <= rx_mode_left[2];
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [KEY_W-1:0] key;
        logic [OP_W-1:0]  op;
        int               pool_size;
        int               pick;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extreme keys, duplicate, absent delete,
        // fill to full, full insert with present key, clear with a hit
        send_request(OP_LOOKUP, '0, 8'h00);
        send_request(OP_INSERT, '0, 8'h00);
        send_request(OP_INSERT, '1, 8'hFF);
        send_request(OP_INSERT, '1, 8'h5A);
        send_request(OP_LOOKUP, '1, 8'h00);
        send_request(OP_DELETE, 64'h1234, 8'h00);
        send_request(OP_DELETE, '0, 8'h00);
        send_request(OP_LOOKUP, '0, 8'hFF);
        for (int i = 1; i < ENTRIES; i++)
            send_request(OP_INSERT, 64'hC0DE_0000_0000_0000 | 64'(i), 8'(i));
        send_request(OP_INSERT, 64'h5555_AAAA_5555_AAAA, 8'hA5);
        send_request(OP_INSERT, '1, 8'h11);
        send_request(OP_CLEAR, '1, 8'h00);
        send_request(OP_LOOKUP, '1, 8'h00);

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_MAX; i++) key_pool[i] = random_key();
        pool_size = POOL_MAX;

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) pool_size = $urandom_range(10, POOL_MAX);
            if (n % 400 == 399)
                for (int i = 2; i < POOL_MAX; i++) key_pool[i] = random_key();
            key  = ($urandom_range(0, 9) == 0) ? random_key()
                                               : key_pool[$urandom_range(0, pool_size - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 50)      op = OP_INSERT;
            else if (pick < 72) op = OP_LOOKUP;
            else if (pick < 97) op = OP_DELETE;
            else                op = OP_CLEAR;
            send_request(op, key, 8'($urandom_range(0, 255)));
        end
        s_axis_tvalid <= 1'b0;

        while (table_model.pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (table_model.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
